// ----- rtl/core/fnf_pkg.sv -----
// Shared types and codes for the gradient-noise flame shader.
// Used by fnf_front, fnf_back and the top level; no dependencies.
`default_nettype none
package fnf_pkg;

    localparam logic [1:0] MODE_SHADE = 2'd0;
    localparam logic [1:0] MODE_PERM  = 2'd1;
    localparam logic [1:0] MODE_GRAD  = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] REG_RISE_SPEED     = 3'd0;
    localparam logic [2:0] REG_FLICKER_SPEED  = 3'd1;
    localparam logic [2:0] REG_FLICKER_DEFORM = 3'd2;
    localparam logic [2:0] REG_FRAME_TIME     = 3'd3;
    localparam logic [2:0] REG_RISE_AXIS      = 3'd4;
    localparam logic [2:0] REG_COLOR_LOW      = 3'd5;
    localparam logic [2:0] REG_COLOR_HIGH     = 3'd6;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [8:0]         table_index;
        logic [8:0]         perm_value;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] grad_z;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic [16:0] rise_rate;
        logic [16:0] flicker_rate;
        logic [16:0] flicker_deform;
        logic [15:0] frame_time;
        logic [47:0] rise_axis;
        logic [23:0] color_low;
        logic [23:0] color_high;
    } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/gradient_noise_flame_shader_unit.sv -----
// Top level of the gradient-noise flame shader: config registers,
// request front end and execution back end. Depends on fnf_pkg, fnf_front, fnf_back.
//
// Usage:
//   Requests enter on start when busy is low; mode selects shade, permutation
//   load or gradient load. Load tables before shading. Mode 3 is dropped.
//   A two-entry queue sits between the front end and the back end, so busy
//   rises only when that queue is full.
//   Each shade request gives one result on alpha/red/green/blue, marked by a
//   one-cycle done strobe; loads give no result. The receiver cannot stall.
//   Each noise value of a shade walks eight lattice corners, in steps set by
//   the chain of three permutation reads and one gradient read through the
//   table memories. A queued shade starts only after the previous one has
//   finished. A load is written into its table as it leaves the queue.
//   Config writes (cfg_we, cfg_index, cfg_data) land at once; write only when
//   idle. Reset clears control state and restores register defaults; table
//   contents stay undefined until loaded.
`default_nettype none
module gradient_noise_flame_shader_unit #(
    parameter int TABLE_SIZE = 512,
    parameter int HASH_MOD   = 256,
    parameter int OCTAVES    = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [8:0]         table_index,
    input  logic [8:0]         perm_value,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    output logic               done,
    output logic signed [19:0] alpha,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import fnf_pkg::*;

    cfg_t   cfg_reg;
    item_t  req;
    qhead_t head;
    logic   pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_rate      <= 17'd65536;
            cfg_reg.flicker_rate   <= 17'd6554;
            cfg_reg.flicker_deform <= 17'd32768;
            cfg_reg.frame_time     <= 16'd64;
            cfg_reg.rise_axis      <= 48'd16384;
            cfg_reg.color_low      <= 24'd0;
            cfg_reg.color_high     <= 24'hFFFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RISE_SPEED:     cfg_reg.rise_rate      <= cfg_data[16:0];
                REG_FLICKER_SPEED:  cfg_reg.flicker_rate   <= cfg_data[16:0];
                REG_FLICKER_DEFORM: cfg_reg.flicker_deform <= cfg_data[16:0];
                REG_FRAME_TIME:     cfg_reg.frame_time     <= cfg_data[15:0];
                REG_RISE_AXIS:      cfg_reg.rise_axis      <= cfg_data;
                REG_COLOR_LOW:      cfg_reg.color_low      <= cfg_data[23:0];
                REG_COLOR_HIGH:     cfg_reg.color_high     <= cfg_data[23:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        req.kind        = mode;
        req.pos_x       = pos_x;
        req.pos_y       = pos_y;
        req.pos_z       = pos_z;
        req.table_index = table_index;
        req.perm_value  = perm_value;
        req.grad_x      = grad_x;
        req.grad_y      = grad_y;
        req.grad_z      = grad_z;
    end

    fnf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    fnf_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .HASH_MOD   (HASH_MOD),
        .OCTAVES    (OCTAVES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .cfg   (cfg_reg),
        .done  (done),
        .alpha (alpha),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

endmodule
`default_nettype wire

// ----- rtl/core/fnf_front.sv -----
// Request front end: takes requests, drops unused modes, queues the rest.
// Depends on fnf_pkg.
`default_nettype none
module fnf_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fnf_pkg::item_t req,
    output fnf_pkg::qhead_t head,
    input  logic           pop
);
    import fnf_pkg::*;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign busy = (count_reg == 2'd2);
    assign push = start && !busy && (req.kind != MODE_NONE);
    assign head.valid = (count_reg != 2'd0);
    assign head.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= req;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/fnf_back.sv -----
// Execution back end: table loads, noise sequencer over lattice corners,
// turbulence, alpha and color blend. Depends on fnf_pkg.
`default_nettype none
module fnf_back #(
    parameter int TABLE_SIZE = 512,
    parameter int HASH_MOD   = 256,
    parameter int OCTAVES    = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fnf_pkg::qhead_t    head,
    output logic               pop,
    input  fnf_pkg::cfg_t      cfg,
    output logic               done,
    output logic signed [19:0] alpha,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);
    import fnf_pkg::*;

    localparam int TW = $clog2(TABLE_SIZE);
    localparam int HB = $clog2(HASH_MOD);
    localparam int PW = $clog2(OCTAVES + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SET1   = 4'd1;
    localparam logic [3:0] ST_SET2   = 4'd2;
    localparam logic [3:0] ST_SET3   = 4'd3;
    localparam logic [3:0] ST_SET4   = 4'd4;
    localparam logic [3:0] ST_CORNER = 4'd5;
    localparam logic [3:0] ST_NDONE  = 4'd6;
    localparam logic [3:0] ST_DISP   = 4'd7;
    localparam logic [3:0] ST_ALPHA  = 4'd8;
    localparam logic [3:0] ST_BLEND  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic [2:0] LAST_STEP   = 3'd6;
    localparam logic [2:0] LAST_CORNER = 3'd7;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    step_reg, step_next;
    logic [2:0]    corner_reg, corner_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic          done_reg;
    logic          perm_we, grad_we;

    logic [8:0]  perm_mem [TABLE_SIZE];
    logic [47:0] grad_mem [TABLE_SIZE];
    logic [8:0]  perm_rd;
    logic [47:0] grad_rd;
    logic [TW-1:0] perm_addr;
    logic [31:0] widx, gidx, hs0, hs1, hs1m, hs2, hs2m;

    logic signed [31:0] pos_reg [3];
    logic [32:0]        prod_r_reg, prod_f_reg;
    logic signed [27:0] rd_reg;
    logic [26:0]        dist_reg;
    logic signed [29:0] off_reg [3];
    logic signed [47:0] p_reg [3];
    logic signed [47:0] np_reg [3];
    logic [16:0]        sq_reg [3];
    logic [16:0]        cu_reg [3];
    logic signed [19:0] f_reg [3];
    logic signed [33:0] gt_reg [3];
    logic signed [23:0] w01_reg;
    logic signed [21:0] dot_reg;
    logic signed [27:0] w_reg;
    logic signed [25:0] sum_reg;
    logic signed [27:0] disp_reg;
    logic signed [29:0] turb_reg;
    logic signed [19:0] alpha_reg;
    logic signed [9:0]  blend_reg [3];
    logic signed [19:0] alpha_out_reg;
    logic [7:0]         col_reg [3];

    logic signed [31:0] lat [3];
    logic signed [17:0] t [3];
    logic [16:0]        a [3];
    logic [33:0]        sqp [3];
    logic [33:0]        cup [3];
    logic signed [19:0] fv [3];
    logic signed [15:0] g [3];
    logic signed [33:0] gtp [3];
    logic signed [39:0] w01p;
    logic signed [35:0] dsum;
    logic signed [43:0] wp;
    logic signed [49:0] termp;
    logic signed [43:0] dispp;
    logic signed [25:0] nsh;
    logic [PW-1:0]      sh;
    logic signed [29:0] asum;
    logic signed [19:0] asat;
    logic signed [15:0] ax [3];
    logic signed [43:0] offp [3];
    logic signed [47:0] pw [3];
    logic signed [47:0] pd [3];
    logic [7:0]         lo [3];
    logic [7:0]         hi [3];
    logic signed [8:0]  diff [3];
    logic signed [25:0] bp [3];

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            lat[d] = $signed(np_reg[d][47:16]) + $signed({31'b0, corner_reg[d]});
            t[d]   = $signed({2'b00, np_reg[d][15:0]}) - (corner_reg[d] ? 18'sd65536 : 18'sd0);
            a[d]   = t[d][17] ? 17'(-t[d]) : 17'(t[d]);
            sqp[d] = a[d] * a[d];
            cup[d] = sq_reg[d] * a[d];
            fv[d]  = 20'sd65536 + $signed({2'b00, cu_reg[d], 1'b0})
                     - $signed({3'b000, sq_reg[d]}) - $signed({2'b00, sq_reg[d], 1'b0});
            g[d]   = $signed(grad_rd[16*d +: 16]);
            gtp[d] = g[d] * t[d];
            ax[d]  = $signed(cfg.rise_axis[16*d +: 16]);
            offp[d] = rd_reg * ax[d];
            pw[d]  = {{16{pos_reg[d][31]}}, pos_reg[d]} + {{18{off_reg[d][29]}}, off_reg[d]};
            pd[d]  = p_reg[d] + {{20{disp_reg[27]}}, disp_reg};
            lo[d]  = cfg.color_low[8*d +: 8];
            hi[d]  = cfg.color_high[8*d +: 8];
            diff[d] = $signed({1'b0, hi[d]}) - $signed({1'b0, lo[d]});
            bp[d]  = diff[d] * $signed({1'b0, alpha_reg[15:0]});
        end
        w01p  = f_reg[0] * f_reg[1];
        dsum  = {{2{gt_reg[0][33]}}, gt_reg[0]} + {{2{gt_reg[1][33]}}, gt_reg[1]}
                + {{2{gt_reg[2][33]}}, gt_reg[2]};
        wp    = w01_reg * f_reg[2];
        termp = w_reg * dot_reg;
        dispp = sum_reg * $signed({1'b0, cfg.flicker_deform});
        sh    = phase_reg - PW'(1);
        nsh   = sum_reg >>> sh;
        asum  = turb_reg + 30'sd32768;
        if (asum > 30'sd524287)
        begin
            asat = 20'sd262143 + 20'sd262144;
        end
        else if (asum < -30'sd524288)
        begin
            asat = {1'b1, 19'b0};
        end
        else
        begin
            asat = asum[19:0];
        end
    end

    always_comb
    begin
        widx = 32'(head.item.table_index);
        gidx = 32'(perm_rd);
        hs0  = 32'(lat[2][HB-1:0]) + 32'(HASH_MOD);
        hs1  = lat[1] + {23'b0, perm_rd};
        hs1m = 32'(hs1[HB-1:0]);
        hs2  = lat[0] + {23'b0, perm_rd};
        hs2m = 32'(hs2[HB-1:0]) + 32'(HASH_MOD);
        case (step_reg)
            3'd0:    perm_addr = hs0[TW-1:0];
            3'd1:    perm_addr = hs1m[TW-1:0];
            default: perm_addr = hs2m[TW-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[widx[TW-1:0]] <= head.item.perm_value;
        end
        perm_rd <= perm_mem[perm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
        begin
            grad_mem[widx[TW-1:0]] <= {head.item.grad_z, head.item.grad_y, head.item.grad_x};
        end
        grad_rd <= grad_mem[gidx[TW-1:0]];
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        corner_next = corner_reg;
        phase_next  = phase_reg;
        pop         = 1'b0;
        perm_we     = 1'b0;
        grad_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    unique case (head.item.kind)
                        MODE_PERM:  perm_we = 1'b1;
                        MODE_GRAD:  grad_we = 1'b1;
                        MODE_SHADE: state_next = ST_SET1;
                        default:    ;
                    endcase
                end
            end
            ST_SET1: state_next = ST_SET2;
            ST_SET2: state_next = ST_SET3;
            ST_SET3: state_next = ST_SET4;
            ST_SET4:
            begin
                step_next   = 3'd0;
                corner_next = 3'd0;
                phase_next  = '0;
                state_next  = ST_CORNER;
            end
            ST_CORNER:
            begin
                if (step_reg == LAST_STEP)
                begin
                    step_next   = 3'd0;
                    corner_next = corner_reg + 3'd1;
                    if (corner_reg == LAST_CORNER)
                    begin
                        state_next = ST_NDONE;
                    end
                end
                else
                begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_NDONE:
            begin
                if (phase_reg == '0)
                begin
                    state_next = ST_DISP;
                end
                else if (phase_reg == PW'(OCTAVES))
                begin
                    state_next = ST_ALPHA;
                end
                else
                begin
                    phase_next = phase_reg + PW'(1);
                    state_next = ST_CORNER;
                end
            end
            ST_DISP:
            begin
                phase_next = PW'(1);
                state_next = ST_CORNER;
            end
            ST_ALPHA: state_next = ST_BLEND;
            ST_BLEND: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= 3'd0;
            corner_reg <= 3'd0;
            phase_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            corner_reg <= corner_next;
            phase_reg  <= phase_next;
            done_reg   <= (state_reg == ST_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                pos_reg[0] <= head.item.pos_x;
                pos_reg[1] <= head.item.pos_y;
                pos_reg[2] <= head.item.pos_z;
            end
            ST_SET1:
            begin
                prod_r_reg <= cfg.rise_rate * cfg.frame_time;
                prod_f_reg <= cfg.flicker_rate * cfg.frame_time;
            end
            ST_SET2:
            begin
                rd_reg   <= -$signed({1'b0, prod_r_reg[32:6]});
                dist_reg <= prod_f_reg[32:6];
            end
            ST_SET3:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    off_reg[d] <= offp[d][43:14];
                end
            end
            ST_SET4:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    p_reg[d]  <= pw[d];
                    np_reg[d] <= pw[d] + {21'b0, dist_reg};
                end
                sum_reg  <= '0;
                turb_reg <= '0;
            end
            ST_CORNER:
            begin
                case (step_reg)
                    3'd1:
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            sq_reg[d] <= sqp[d][32:16];
                        end
                    end
                    3'd2:
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            cu_reg[d] <= cup[d][32:16];
                        end
                    end
                    3'd3:
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            f_reg[d] <= fv[d];
                        end
                    end
                    3'd4:
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            gt_reg[d] <= gtp[d];
                        end
                        w01_reg <= w01p[39:16];
                    end
                    3'd5:
                    begin
                        dot_reg <= dsum[35:14];
                        w_reg   <= wp[43:16];
                    end
                    3'd6:    sum_reg <= sum_reg + termp[41:16];
                    default: ;
                endcase
            end
            ST_NDONE:
            begin
                if (phase_reg == '0)
                begin
                    disp_reg <= dispp[43:16];
                end
                else
                begin
                    turb_reg <= turb_reg + {{4{nsh[25]}}, nsh};
                    for (int d = 0; d < 3; d++)
                    begin
                        p_reg[d]  <= p_reg[d] <<< 1;
                        np_reg[d] <= p_reg[d] <<< 1;
                    end
                end
                sum_reg <= '0;
            end
            ST_DISP:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    p_reg[d]  <= pd[d];
                    np_reg[d] <= pd[d];
                end
                sum_reg <= '0;
            end
            ST_ALPHA: alpha_reg <= asat;
            ST_BLEND:
            begin
                for (int d = 0; d < 3; d++)
                begin
                    blend_reg[d] <= bp[d][25:16];
                end
            end
            ST_OUT:
            begin
                alpha_out_reg <= alpha_reg;
                for (int d = 0; d < 3; d++)
                begin
                    if (alpha_reg >= 20'sd65536)
                    begin
                        col_reg[d] <= hi[d];
                    end
                    else if (alpha_reg[19])
                    begin
                        col_reg[d] <= lo[d];
                    end
                    else
                    begin
                        col_reg[d] <= lo[d] + blend_reg[d][7:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign alpha = alpha_out_reg;
    assign red   = col_reg[0];
    assign green = col_reg[1];
    assign blue  = col_reg[2];

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("done held longer than one cycle");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head.valid)
        else $error("pop from empty queue");
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORNER) |-> (step_reg <= LAST_STEP))
        else $error("corner step out of range");

endmodule
`default_nettype wire
